// ===== rtl/fmh_pkg.sv =====
// shared constants, types and the fnv prime multiply for the multi-lane hash
package fmh_pkg;

    localparam int WORD_W         = 64;
    localparam int BYTE_W         = 8;
    localparam int BYTES_PER_WORD = WORD_W / BYTE_W;
    localparam int QUEUE_DEPTH_DEF = 4;

    localparam logic [WORD_W-1:0] FNV_BASIS = 64'hcbf29ce484222325;
    localparam logic [WORD_W-1:0] FNV_PRIME = 64'h00000100000001b3;

    // lane hash of one word plus its end-of-message mark
    typedef struct packed {
        logic [WORD_W-1:0] lane;
        logic              last;
    } q_item_t;

    // multiply by the fnv prime 2^40 + 0x1b3, modulo 2^64, as shifts and adds
    function automatic logic [WORD_W-1:0] fnv_mul(input logic [WORD_W-1:0] h);
        return (h << 40) + (h << 8) + (h << 7) + (h << 5) + (h << 4) + (h << 1) + h;
    endfunction

endpackage

// ===== rtl/fmh_front.sv =====
// front end: accepts words and forms each lane hash, one byte per stage
module fmh_front (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    output logic                         full,
    input  logic [fmh_pkg::WORD_W-1:0]   word,
    input  logic                         last,
    output logic                         q_push,
    input  logic                         q_full,
    output fmh_pkg::q_item_t             q_item
);
    import fmh_pkg::*;

    localparam int NB = BYTES_PER_WORD;

    logic              vld_reg  [NB];
    logic [WORD_W-1:0] hash_reg [NB];
    logic [WORD_W-1:0] word_reg [NB];
    logic              last_reg [NB];
    logic              adv;

    // the whole pipe moves unless the finished lane cannot enter the queue
    assign adv    = !(vld_reg[NB-1] && q_full);
    assign full   = !adv;
    assign q_push = vld_reg[NB-1] && !q_full;

    assign q_item.lane = hash_reg[NB-1];
    assign q_item.last = last_reg[NB-1];

    // stage valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < NB; s++)
            begin
                vld_reg[s] <= 1'b0;
            end
        end
        else if (adv)
        begin
            vld_reg[0] <= push;
            for (int s = 1; s < NB; s++)
            begin
                vld_reg[s] <= vld_reg[s-1];
            end
        end
    end

    // first byte: lane hash starts from zero
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            hash_reg[0] <= fnv_mul({{(WORD_W-BYTE_W){1'b0}}, word[BYTE_W-1:0]});
            word_reg[0] <= word >> BYTE_W;
            last_reg[0] <= last;
        end
    end

    // remaining bytes, least significant first
    for (genvar s = 1; s < NB; s++)
    begin : g_stage
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                hash_reg[s] <= fnv_mul(hash_reg[s-1] ^
                                       {{(WORD_W-BYTE_W){1'b0}}, word_reg[s-1][BYTE_W-1:0]});
                word_reg[s] <= word_reg[s-1] >> BYTE_W;
                last_reg[s] <= last_reg[s-1];
            end
        end
    end

endmodule

// ===== rtl/fmh_fifo.sv =====
// short queue of lane hashes between the front and back ends
module fmh_fifo #(
    parameter int DEPTH = fmh_pkg::QUEUE_DEPTH_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  fmh_pkg::q_item_t wr_item,
    output logic             q_full,
    input  logic             rd_en,
    output fmh_pkg::q_item_t rd_item,
    output logic             q_empty
);
    import fmh_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    q_item_t            mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               do_wr, do_rd;

    assign q_full  = (cnt_reg == CNT_W'(DEPTH));
    assign q_empty = (cnt_reg == '0);
    assign do_wr   = wr_en && !q_full;
    assign do_rd   = rd_en && !q_empty;
    assign rd_item = mem_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_item;
        end
    end

endmodule

// ===== rtl/fmh_back.sv =====
// back end: folds lane hashes into the running hash and holds the digest
module fmh_back (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         q_empty,
    input  fmh_pkg::q_item_t             q_item,
    output logic                         q_pop,
    output logic                         empty,
    input  logic                         pop,
    output logic [fmh_pkg::WORD_W-1:0]   digest
);
    import fmh_pkg::*;

    logic [WORD_W-1:0] run_reg, run_next;
    logic [WORD_W-1:0] digest_reg;
    logic              out_vld_reg, out_vld_next;
    logic [WORD_W-1:0] mixed;
    logic              take;

    // a last item needs a free result slot, others go straight through
    assign take   = !q_empty && (!q_item.last || !out_vld_reg || pop);
    assign q_pop  = take;
    assign mixed  = fnv_mul(run_reg ^ q_item.lane);
    assign empty  = !out_vld_reg;
    assign digest = digest_reg;

    // running hash and result slot
    always_comb
    begin
        run_next     = run_reg;
        out_vld_next = out_vld_reg && !pop;
        if (take)
        begin
            if (q_item.last)
            begin
                run_next     = FNV_BASIS;
                out_vld_next = 1'b1;
            end
            else
            begin
                run_next = mixed;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg     <= FNV_BASIS;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            run_reg     <= run_next;
            out_vld_reg <= out_vld_next;
        end
    end

    // digest capture
    always_ff @(posedge clk)
    begin
        if (take && q_item.last)
        begin
            digest_reg <= mixed;
        end
    end

endmodule

// ===== rtl/multilane_fnv1a_hash64.sv =====
// multi-lane fnv-1a 64-bit hash: top level joining front end, queue and back end
// a last word reaches digest through the front pipe, the queue and the back end (empty low)
// throughput: one word per cycle while full is low; the front pipe takes one byte
// per stage over 8 stages, the back end does one xor and prime multiply per word
// reset: rst_n asynchronous, active low; empties pipe, queue and result slot,
// running hash returns to the offset basis
module multilane_fnv1a_hash64 #(
    parameter int QUEUE_DEPTH = fmh_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    output logic                         full,
    input  logic [fmh_pkg::WORD_W-1:0]   word,
    input  logic                         last,
    output logic                         empty,
    input  logic                         pop,
    output logic [fmh_pkg::WORD_W-1:0]   digest
);
    import fmh_pkg::*;

    logic    q_push, q_full, q_pop, q_empty;
    q_item_t wr_item, rd_item;

    // lane hash pipeline
    fmh_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .word   (word),
        .last   (last),
        .q_push (q_push),
        .q_full (q_full),
        .q_item (wr_item)
    );

    // decoupling queue
    fmh_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_push),
        .wr_item (wr_item),
        .q_full  (q_full),
        .rd_en   (q_pop),
        .rd_item (rd_item),
        .q_empty (q_empty)
    );

    // running combine and result
    fmh_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .q_item  (rd_item),
        .q_pop   (q_pop),
        .empty   (empty),
        .pop     (pop),
        .digest  (digest)
    );

endmodule

// ===== rtl/fmh_checker.sv =====
// port-level checks for the multi-lane hash, bound to the top level
module fmh_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        push,
    input logic        full,
    input logic [63:0] word,
    input logic        last,
    input logic        empty,
    input logic        pop,
    input logic [63:0] digest
);
    logic [5:0] pend_reg, pend_next;
    logic       in_last, out_take;

    assign in_last  = push && !full && last;
    assign out_take = pop && !empty;

    // count of messages closed but not yet delivered
    always_comb
    begin
        pend_next = pend_reg;
        if (in_last && !out_take)
        begin
            pend_next = pend_reg + 1'b1;
        end
        else if (out_take && !in_last)
        begin
            pend_next = pend_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
        end
        else
        begin
            pend_reg <= pend_next;
        end
    end

    // no result without a closed message
    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> pend_reg != 6'd0)
        else $error("result shown with no closed message");

    // a closed message cannot come out on the very next cycle
    a_min_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (in_last && pend_reg == 6'd0) |=> empty)
        else $error("digest shown too early");

    // a waiting digest holds until taken
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(digest)))
        else $error("waiting digest changed or vanished");

    // an accepted word carries no unknown bits
    a_word_known: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !full) |-> !$isunknown(word))
        else $error("accepted word has unknown bits");

endmodule

bind multilane_fnv1a_hash64 fmh_checker u_fmh_checker (.*);

// ===== test/tb_top.sv =====
// self-checking testbench for the streaming multi-lane fnv-1a 64-bit hash
`timescale 1ns / 1ps

module tb_top;

    import fmh_pkg::*;

    localparam int TOTAL_WORDS   = 1650;
    localparam int QUIET_FROM    = 1450;
    localparam int DRAIN_CYCLES  = 24;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int MAX_PRINTED   = 40;
    localparam int N_DIRECTED    = 20;

    typedef struct packed {
        logic [WORD_W-1:0] w;
        logic              l;
    } word_row_t;

    logic              clk;
    logic              rst_n;
    logic              push;
    logic              full;
    logic [WORD_W-1:0] word;
    logic              last;
    logic              empty;
    logic              pop;
    logic [WORD_W-1:0] digest;

    // running hash of the message in flight and digests still owed by the block
    logic [WORD_W-1:0] msg_hash;
    logic [WORD_W-1:0] expected_digests [$];
    logic [WORD_W-1:0] want_digest;

    int  mismatches;
    int  cycle_count;
    int  words_sent;
    int  stall_left;
    bit  idling;

    // directed words; digests are not hand-checkable so every row goes through the predictor
    word_row_t directed_rows [N_DIRECTED] = '{
        '{64'h0000000000000000, 1'b1},   // one-word message right after reset
        '{64'hffffffffffffffff, 1'b1},   // one-word message right after another end
        '{64'h0000000000000001, 1'b0},
        '{64'h8000000000000000, 1'b1},
        '{64'haaaaaaaaaaaaaaaa, 1'b0},
        '{64'h5555555555555555, 1'b0},
        '{64'h00000000000000ff, 1'b0},
        '{64'hff00000000000000, 1'b1},
        '{64'h0123456789abcdef, 1'b1},
        '{64'hfedcba9876543210, 1'b0},
        '{64'hcbf29ce484222325, 1'b0},
        '{64'h00000100000001b3, 1'b1},
        '{64'hffffffffffffffff, 1'b0},
        '{64'hffffffffffffffff, 1'b0},
        '{64'hffffffffffffffff, 1'b0},
        '{64'h0000000000000000, 1'b0},
        '{64'h0000000000000000, 1'b0},
        '{64'hffffffffffffffff, 1'b1},
        '{64'h0000000080000000, 1'b1},
        '{64'h7fffffffffffffff, 1'b1}
    };

    multilane_fnv1a_hash64 DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .word   (word),
        .last   (last),
        .empty  (empty),
        .pop    (pop),
        .digest (digest)
    );

    // clock
    always #1 clk = ~clk;

    // fnv-1a over the eight bytes of one word, starting from zero
    function automatic logic [WORD_W-1:0] word_lane(input logic [WORD_W-1:0] w);
        logic [WORD_W-1:0] h;
        h = '0;
        for (int b = 0; b < BYTES_PER_WORD; b++)
        begin
            h = (h ^ {{(WORD_W-BYTE_W){1'b0}}, w[BYTE_W*b +: BYTE_W]}) * FNV_PRIME;
        end
        return h;
    endfunction

    // fold one accepted word into the message hash, queue a digest on the end mark
    task automatic fold_word(input logic [WORD_W-1:0] w, input logic l);
        msg_hash = (msg_hash ^ word_lane(w)) * FNV_PRIME;
        if (l)
        begin
            expected_digests.push_back(msg_hash);
            msg_hash = FNV_BASIS;
        end
    endtask

    task automatic report_mismatch(input string what);
        if (mismatches < MAX_PRINTED)
        begin
            $display("[%0d] mismatch: %s", cycle_count, what);
        end
        mismatches++;
    endtask

    // random word, biased toward byte-level corner patterns
    function automatic logic [WORD_W-1:0] pick_word();
        logic [WORD_W-1:0] w;
        case ($urandom_range(0, 9))
            0:       w = '0;
            1:       w = '1;
            2:       w = {56'b0, 8'($urandom)} << (BYTE_W * $urandom_range(0, 7));
            3:       w = 64'b1 << $urandom_range(0, 63);
            4:       w = ~(64'b1 << $urandom_range(0, 63));
            default: w = {$urandom, $urandom};
        endcase
        return w;
    endfunction

    // present one item; called and returns at a falling edge
    task automatic send_word(input logic [WORD_W-1:0] w, input logic l);
        int gap;
        if (idling && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 16);
            push <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        push <= 1'b1;
        word <= w;
        last <= l;
        do @(posedge clk); while (full);
        fold_word(w, l);
        words_sent++;
        @(negedge clk);
    endtask

    // receiver: pop with random stall bursts
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            pop <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            pop <= 1'b0;
        end
        else if (idling && $urandom_range(0, 5) == 0)
        begin
            stall_left = $urandom_range(1, 16) - 1;
            pop <= 1'b0;
        end
        else
        begin
            pop <= 1'b1;
        end
    end

    // result check against the oldest owed digest
    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
        begin
            if (expected_digests.size() == 0)
            begin
                report_mismatch($sformatf("digest %h with no message pending", digest));
            end
            else
            begin
                want_digest = expected_digests.pop_front();
                if (digest !== want_digest)
                begin
                    report_mismatch($sformatf("digest %h, want %h", digest, want_digest));
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout with %0d digests outstanding", expected_digests.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    // stimulus and end of run
    initial
    begin
        int len;
        clk         = 1'b0;
        rst_n       = 1'b0;
        push        = 1'b0;
        pop         = 1'b0;
        word        = '0;
        last        = 1'b0;
        msg_hash    = FNV_BASIS;
        mismatches  = 0;
        cycle_count = 0;
        words_sent  = 0;
        stall_left  = 0;
        idling      = 1'b1;

        repeat (11) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed part
        foreach (directed_rows[i])
        begin
            send_word(directed_rows[i].w, directed_rows[i].l);
        end

        // random messages, mostly short, a few long
        while (words_sent < TOTAL_WORDS)
        begin
            idling = (words_sent < QUIET_FROM) && ($urandom_range(0, 3) != 0);
            case ($urandom_range(0, 7))
                0:       len = 1;
                1:       len = $urandom_range(17, 40);
                default: len = $urandom_range(2, 12);
            endcase
            for (int i = 0; i < len; i++)
            begin
                send_word(pick_word(), i == len - 1);
            end
        end
        push <= 1'b0;

        // drain
        while (expected_digests.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/fmh_pkg.sv
rtl/fmh_front.sv
rtl/fmh_fifo.sv
rtl/fmh_back.sv
rtl/multilane_fnv1a_hash64.sv
rtl/fmh_checker.sv
test/tb_top.sv
